FILE: src/cpbl_pkg.sv
// Package for the clip player / breathing LED controller.
// Holds the clip tables, input kind codes and the front-to-back command type.
// No dependencies.
package cpbl_pkg;

    // Samples per second of the stored clips
    localparam int unsigned SAMPLE_RATE = 8000;

    // Serial memory read command
    localparam logic [7:0] READ_CMD = 8'h03;

    // Widths fixed by the item fields and state
    localparam int unsigned CLIP_W     = 3;
    localparam int unsigned LEN_W      = 17;
    localparam int unsigned LEVEL_W    = 4;
    localparam int unsigned ADDR_MAX_W = 24;
    localparam int unsigned TAB_DEPTH  = 8;

    // Defaults for the top-level parameters
    localparam int unsigned NUM_CLIPS_DEF        = 5;
    localparam int unsigned LED_LEVELS_DEF       = 10;
    localparam int unsigned LED_STEP_SAMPLES_DEF = 400;
    localparam int unsigned ADDR_BITS_DEF        = 24;
    localparam int unsigned FIFO_DEPTH_DEF       = 4;

    // Input kind codes
    localparam logic KIND_BUTTON = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    // Clip lengths in samples; entries past the fifth repeat the table
    localparam logic [LEN_W-1:0] CLIP_LEN [TAB_DEPTH] = '{
        LEN_W'(SAMPLE_RATE * 85 / 10), LEN_W'(SAMPLE_RATE * 4),
        LEN_W'(SAMPLE_RATE * 3),       LEN_W'(SAMPLE_RATE * 94 / 10),
        LEN_W'(SAMPLE_RATE * 72 / 10), LEN_W'(SAMPLE_RATE * 85 / 10),
        LEN_W'(SAMPLE_RATE * 4),       LEN_W'(SAMPLE_RATE * 3)
    };

    // Clip start addresses in the serial memory
    localparam logic [ADDR_MAX_W-1:0] CLIP_START [TAB_DEPTH] = '{
        ADDR_MAX_W'(0),                        ADDR_MAX_W'(SAMPLE_RATE * 91 / 10),
        ADDR_MAX_W'(SAMPLE_RATE * 138 / 10),   ADDR_MAX_W'(SAMPLE_RATE * 174 / 10),
        ADDR_MAX_W'(SAMPLE_RATE * 278 / 10),   ADDR_MAX_W'(0),
        ADDR_MAX_W'(SAMPLE_RATE * 91 / 10),    ADDR_MAX_W'(SAMPLE_RATE * 138 / 10)
    };

    // Command from the front to the back, beside the start address
    typedef struct packed {
        logic       is_start;   // clip start: four memory bytes
        logic       led;        // LED level for a sample result
        logic       done;       // sample ends the clip
        logic [7:0] duty;       // PWM duty after this item
    } t_cmd;

endpackage

FILE: src/cpbl_fifo.sv
// Small command queue between the front and the back.
// Register storage, one write and one read port. Generic, no package use.
module cpbl_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: src/cpbl_front.sv
// Front part: accepts button and sample items, keeps the player state and
// queues one command per item that produces results. Uses cpbl_pkg.
module cpbl_front #(
    parameter int unsigned NUM_CLIPS        = cpbl_pkg::NUM_CLIPS_DEF,
    parameter int unsigned LED_LEVELS       = cpbl_pkg::LED_LEVELS_DEF,
    parameter int unsigned LED_STEP_SAMPLES = cpbl_pkg::LED_STEP_SAMPLES_DEF,
    parameter int unsigned ADDR_BITS        = cpbl_pkg::ADDR_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_kind,
    input  logic [7:0]           i_sample_byte,
    input  logic                 i_full,
    output logic                 o_stall,
    output logic                 o_push,
    output cpbl_pkg::t_cmd       o_cmd,
    output logic [ADDR_BITS-1:0] o_addr
);

    localparam int unsigned STEP_W = (LED_STEP_SAMPLES > 1) ? $clog2(LED_STEP_SAMPLES) : 1;
    localparam int unsigned LV_W   = $clog2(LED_LEVELS);
    localparam int unsigned CW     = cpbl_pkg::CLIP_W;
    localparam int unsigned LW     = cpbl_pkg::LEN_W;
    localparam int unsigned VW     = cpbl_pkg::LEVEL_W;

    // Clip lengths reduced by the LED step and level counts
    localparam logic [STEP_W-1:0] LEN_MOD_STEP [cpbl_pkg::TAB_DEPTH] = '{
        STEP_W'(cpbl_pkg::CLIP_LEN[0] % LED_STEP_SAMPLES),
        STEP_W'(cpbl_pkg::CLIP_LEN[1] % LED_STEP_SAMPLES),
        STEP_W'(cpbl_pkg::CLIP_LEN[2] % LED_STEP_SAMPLES),
        STEP_W'(cpbl_pkg::CLIP_LEN[3] % LED_STEP_SAMPLES),
        STEP_W'(cpbl_pkg::CLIP_LEN[4] % LED_STEP_SAMPLES),
        STEP_W'(cpbl_pkg::CLIP_LEN[5] % LED_STEP_SAMPLES),
        STEP_W'(cpbl_pkg::CLIP_LEN[6] % LED_STEP_SAMPLES),
        STEP_W'(cpbl_pkg::CLIP_LEN[7] % LED_STEP_SAMPLES)
    };
    localparam logic [LV_W-1:0] LEN_MOD_LVL [cpbl_pkg::TAB_DEPTH] = '{
        LV_W'(cpbl_pkg::CLIP_LEN[0] % LED_LEVELS),
        LV_W'(cpbl_pkg::CLIP_LEN[1] % LED_LEVELS),
        LV_W'(cpbl_pkg::CLIP_LEN[2] % LED_LEVELS),
        LV_W'(cpbl_pkg::CLIP_LEN[3] % LED_LEVELS),
        LV_W'(cpbl_pkg::CLIP_LEN[4] % LED_LEVELS),
        LV_W'(cpbl_pkg::CLIP_LEN[5] % LED_LEVELS),
        LV_W'(cpbl_pkg::CLIP_LEN[6] % LED_LEVELS),
        LV_W'(cpbl_pkg::CLIP_LEN[7] % LED_LEVELS)
    };

    // Player state; the two remainders track samples_left mod step and mod levels
    logic              r_playing;
    logic [CW-1:0]     r_clip;
    logic [LW-1:0]     r_left;
    logic [STEP_W-1:0] r_rem_step;
    logic [LV_W-1:0]   r_rem_lvl;
    logic [VW-1:0]     r_level;
    logic              r_falling;
    logic [7:0]        r_duty;

    logic              n_playing;
    logic [CW-1:0]     n_clip;
    logic [LW-1:0]     n_left;
    logic [STEP_W-1:0] n_rem_step;
    logic [LV_W-1:0]   n_rem_lvl;
    logic [VW-1:0]     n_level;
    logic              n_falling;
    logic [7:0]        n_duty;

    logic          accept, is_start, is_tick, clip_end, led;
    logic [VW-1:0] lvl_up, lvl_dn;
    logic [CW:0]   clip_inc;

    assign o_stall  = i_full;
    assign accept   = i_valid && !i_full;
    assign is_start = accept && (i_kind == cpbl_pkg::KIND_BUTTON) && !r_playing;
    assign is_tick  = accept && (i_kind == cpbl_pkg::KIND_TICK) && r_playing;
    assign clip_end = (r_left <= LW'(1));
    assign lvl_up   = r_level + 1'b1;
    assign lvl_dn   = r_level - 1'b1;
    assign clip_inc = {1'b0, r_clip} + 1'b1;

    // Work out the next state for a start or a sample
    always_comb begin
        n_playing  = r_playing;
        n_clip     = r_clip;
        n_left     = r_left;
        n_rem_step = r_rem_step;
        n_rem_lvl  = r_rem_lvl;
        n_level    = r_level;
        n_falling  = r_falling;
        n_duty     = r_duty;
        led        = 1'b1;
        if (is_start) begin
            n_playing  = 1'b1;
            n_left     = cpbl_pkg::CLIP_LEN[r_clip];
            n_rem_step = LEN_MOD_STEP[r_clip];
            n_rem_lvl  = LEN_MOD_LVL[r_clip];
            n_level    = '0;
            n_falling  = 1'b0;
        end else if (is_tick) begin
            n_duty = i_sample_byte;
            // Step the breathing level on each step boundary
            if (r_rem_step == '0) begin
                if (!r_falling) begin
                    n_level   = lvl_up;
                    n_falling = (lvl_up == VW'(LED_LEVELS));
                end else begin
                    n_level   = lvl_dn;
                    n_falling = (lvl_dn != '0);
                end
            end
            led = (VW'(r_rem_lvl) < n_level);
            if (clip_end) begin
                n_playing = 1'b0;
                n_left    = '0;
                n_clip    = (clip_inc >= (CW + 1)'(NUM_CLIPS)) ? '0 : clip_inc[CW-1:0];
                led       = 1'b1;
            end else begin
                n_left     = r_left - 1'b1;
                n_rem_step = (r_rem_step == '0) ? STEP_W'(LED_STEP_SAMPLES - 1)
                                                : r_rem_step - 1'b1;
                n_rem_lvl  = (r_rem_lvl == '0) ? LV_W'(LED_LEVELS - 1) : r_rem_lvl - 1'b1;
            end
        end
    end

    // Hold player state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_playing  <= 1'b0;
            r_clip     <= '0;
            r_left     <= '0;
            r_rem_step <= '0;
            r_rem_lvl  <= '0;
            r_level    <= '0;
            r_falling  <= 1'b0;
            r_duty     <= '0;
        end else begin
            r_playing  <= n_playing;
            r_clip     <= n_clip;
            r_left     <= n_left;
            r_rem_step <= n_rem_step;
            r_rem_lvl  <= n_rem_lvl;
            r_level    <= n_level;
            r_falling  <= n_falling;
            r_duty     <= n_duty;
        end
    end

    // Queue one command per item that produces results
    assign o_push         = is_start || is_tick;
    assign o_cmd.is_start = is_start;
    assign o_cmd.led      = led;
    assign o_cmd.done     = is_tick && clip_end;
    assign o_cmd.duty     = n_duty;
    assign o_addr         = cpbl_pkg::CLIP_START[r_clip][ADDR_BITS-1:0];

endmodule

FILE: src/cpbl_back.sv
// Back part: expands queued commands into result transfers and holds them
// in an output register. Uses cpbl_pkg.
module cpbl_back #(
    parameter int unsigned ADDR_BITS = cpbl_pkg::ADDR_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  cpbl_pkg::t_cmd       i_cmd,
    input  logic [ADDR_BITS-1:0] i_addr,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [7:0]           o_mem_byte,
    output logic                 o_mem_byte_valid,
    output logic                 o_select_active,
    output logic [7:0]           o_pwm_duty,
    output logic                 o_pwm_on,
    output logic                 o_led_on,
    output logic                 o_clip_done,
    output logic                 o_last_of_run
);

    // Beats of a clip start
    localparam logic [1:0] BEAT_CMD  = 2'd0;
    localparam logic [1:0] BEAT_HIGH = 2'd1;
    localparam logic [1:0] BEAT_MID  = 2'd2;
    localparam logic [1:0] BEAT_LOW  = 2'd3;

    logic [1:0] r_beat;
    logic       r_valid;
    logic [7:0] r_mem_byte;
    logic       r_mem_byte_valid, r_select, r_pwm_on, r_led, r_done, r_last;
    logic [7:0] r_duty;

    logic [7:0] n_mem_byte;
    logic       n_mem_byte_valid, n_select, n_pwm_on, n_led, n_done, n_last;

    logic                                 load, fire;
    logic [cpbl_pkg::ADDR_MAX_W-1:0]      addr_ext;

    assign load     = !r_valid || !i_stall;
    assign fire     = load && !i_empty;
    assign addr_ext = cpbl_pkg::ADDR_MAX_W'(i_addr);
    assign o_pop    = fire && n_last;

    // Build the result for the head command and current beat
    always_comb begin
        if (i_cmd.is_start) begin
            case (r_beat)
                BEAT_CMD:  n_mem_byte = cpbl_pkg::READ_CMD;
                BEAT_HIGH: n_mem_byte = addr_ext[23:16];
                BEAT_MID:  n_mem_byte = addr_ext[15:8];
                BEAT_LOW:  n_mem_byte = addr_ext[7:0];
                default:   n_mem_byte = cpbl_pkg::READ_CMD;
            endcase
            n_mem_byte_valid = 1'b1;
            n_select         = 1'b1;
            n_pwm_on         = (r_beat == BEAT_LOW);
            n_led            = 1'b1;
            n_done           = 1'b0;
            n_last           = (r_beat == BEAT_LOW);
        end else begin
            n_mem_byte       = '0;
            n_mem_byte_valid = 1'b0;
            n_select         = !i_cmd.done;
            n_pwm_on         = !i_cmd.done;
            n_led            = i_cmd.led;
            n_done           = i_cmd.done;
            n_last           = 1'b1;
        end
    end

    // Advance the beat and the output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= BEAT_CMD;
        end else begin
            if (fire) begin
                r_valid <= 1'b1;
                r_beat  <= n_last ? BEAT_CMD : r_beat + 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Load the output register on each transfer slot
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_mem_byte       <= n_mem_byte;
            r_mem_byte_valid <= n_mem_byte_valid;
            r_select         <= n_select;
            r_duty           <= i_cmd.duty;
            r_pwm_on         <= n_pwm_on;
            r_led            <= n_led;
            r_done           <= n_done;
            r_last           <= n_last;
        end
    end

    assign o_valid          = r_valid;
    assign o_mem_byte       = r_mem_byte;
    assign o_mem_byte_valid = r_mem_byte_valid;
    assign o_select_active  = r_select;
    assign o_pwm_duty       = r_duty;
    assign o_pwm_on         = r_pwm_on;
    assign o_led_on         = r_led;
    assign o_clip_done      = r_done;
    assign o_last_of_run    = r_last;

endmodule

FILE: src/clip_player_breathing_led_top.sv
// Top level of the clip player / breathing LED controller.
// Instantiates cpbl_front, cpbl_fifo and cpbl_back; uses cpbl_pkg.

// An input item is taken every cycle while the command queue (FIFO_DEPTH
// entries) has room. A sample tick during playback yields one result; a button
// press while idle yields four results (read command, then the start address
// high byte first), one per cycle from the output register while the receiver
// does not stall, so a start holds the back end until all four have gone. Items
// that yield nothing (button during playback, tick while idle) are taken and
// dropped. The output register is loaded whenever it is empty or its result is
// taken, so results stream at one per cycle without stall. Each result passes
// from the queue head into the output register before it appears.
module clip_player_breathing_led_top #(
    parameter int unsigned NUM_CLIPS        = cpbl_pkg::NUM_CLIPS_DEF,
    parameter int unsigned LED_LEVELS       = cpbl_pkg::LED_LEVELS_DEF,
    parameter int unsigned LED_STEP_SAMPLES = cpbl_pkg::LED_STEP_SAMPLES_DEF,
    parameter int unsigned ADDR_BITS        = cpbl_pkg::ADDR_BITS_DEF,
    parameter int unsigned FIFO_DEPTH       = cpbl_pkg::FIFO_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_kind,
    input  logic [7:0] i_sample_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_mem_byte,
    output logic       o_mem_byte_valid,
    output logic       o_select_active,
    output logic [7:0] o_pwm_duty,
    output logic       o_pwm_on,
    output logic       o_led_on,
    output logic       o_clip_done,
    output logic       o_last_of_run
);

    localparam int unsigned CMD_W = $bits(cpbl_pkg::t_cmd);
    localparam int unsigned Q_W   = CMD_W + ADDR_BITS;

    logic                 full, empty, push, pop;
    cpbl_pkg::t_cmd       front_cmd, back_cmd;
    logic [ADDR_BITS-1:0] front_addr, back_addr;
    logic [Q_W-1:0]       q_in, q_out;

    // Accept and classify items
    cpbl_front #(
        .NUM_CLIPS        (NUM_CLIPS),
        .LED_LEVELS       (LED_LEVELS),
        .LED_STEP_SAMPLES (LED_STEP_SAMPLES),
        .ADDR_BITS        (ADDR_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_kind        (i_kind),
        .i_sample_byte (i_sample_byte),
        .i_full        (full),
        .o_stall       (o_stall),
        .o_push        (push),
        .o_cmd         (front_cmd),
        .o_addr        (front_addr)
    );

    // Queue commands between the two sides
    assign q_in = {front_cmd, front_addr};

    cpbl_fifo #(
        .WIDTH (Q_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (q_out)
    );

    assign back_cmd  = cpbl_pkg::t_cmd'(q_out[Q_W-1:ADDR_BITS]);
    assign back_addr = q_out[ADDR_BITS-1:0];

    // Expand commands into result transfers
    cpbl_back #(
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_empty          (empty),
        .i_cmd            (back_cmd),
        .i_addr           (back_addr),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_mem_byte       (o_mem_byte),
        .o_mem_byte_valid (o_mem_byte_valid),
        .o_select_active  (o_select_active),
        .o_pwm_duty       (o_pwm_duty),
        .o_pwm_on         (o_pwm_on),
        .o_led_on         (o_led_on),
        .o_clip_done      (o_clip_done),
        .o_last_of_run    (o_last_of_run)
    );

endmodule

FILE: test/clip_player_breathing_led_top_tb.sv
`timescale 1ns / 100ps
// Testbench for clip_player_breathing_led_top: predicts each result transfer from its
// own model of the clip player and compares the results in order, under random idling.
// Depends on cpbl_pkg and the top level; reads no files.
module clip_player_breathing_led_top_tb;

    localparam int unsigned NUM_CLIPS        = 5;
    localparam int unsigned LED_LEVELS       = 10;
    localparam int unsigned LED_STEP_SAMPLES = 400;
    localparam int unsigned ADDR_BITS        = 24;
    localparam int unsigned CLIP_RATE        = 8000;
    // About 180 items are sent; a run that reaches this limit is taken as hung
    localparam int unsigned CYCLE_LIMIT      = 50_000;
    localparam int unsigned HOLD_CYCLES      = 64;
    localparam int unsigned SETTLE_CYCLES    = 16;
    localparam int unsigned MAX_PRINTS       = 40;

    typedef struct packed {
        logic [7:0] mem_byte;
        logic       mem_byte_valid;
        logic       select_active;
        logic [7:0] pwm_duty;
        logic       pwm_on;
        logic       led_on;
        logic       clip_done;
        logic       last_of_run;
    } t_player_out;

    // Player state copy and the queue of results it predicts
    class player_scoreboard;
        bit          playing;
        bit [2:0]    clip_no;
        bit [16:0]   left;
        bit [3:0]    level;
        bit          falling;
        bit [7:0]    duty;
        t_player_out pending[$];
        int unsigned errors;
        int unsigned checked;
        int unsigned starts;
        int unsigned clips_ended;

        function new();
            playing     = 1'b0;
            clip_no     = '0;
            left        = '0;
            level       = '0;
            falling     = 1'b0;
            duty        = '0;
            errors      = 0;
            checked     = 0;
            starts      = 0;
            clips_ended = 0;
        endfunction

        // Table entries past the fifth repeat from the first
        function bit [16:0] clip_length(bit [2:0] n);
            case (n % 5)
                0:       return 17'(CLIP_RATE * 85 / 10);
                1:       return 17'(CLIP_RATE * 4);
                2:       return 17'(CLIP_RATE * 3);
                3:       return 17'(CLIP_RATE * 94 / 10);
                default: return 17'(CLIP_RATE * 72 / 10);
            endcase
        endfunction

        function bit [23:0] clip_address(bit [2:0] n);
            int unsigned a;
            case (n % 5)
                0:       a = 0;
                1:       a = CLIP_RATE * 91 / 10;
                2:       a = CLIP_RATE * 138 / 10;
                3:       a = CLIP_RATE * 174 / 10;
                default: a = CLIP_RATE * 278 / 10;
            endcase
            return 24'(a & ((32'd1 << ADDR_BITS) - 1));
        endfunction

        function void add_out(bit [7:0] mb, bit mbv, bit sel, bit pwm, bit led,
                              bit done, bit last);
            t_player_out r;
            r.mem_byte       = mb;
            r.mem_byte_valid = mbv;
            r.select_active  = sel;
            r.pwm_duty       = duty;
            r.pwm_on         = pwm;
            r.led_on         = led;
            r.clip_done      = done;
            r.last_of_run    = last;
            pending.push_back(r);
        endfunction

        // Advance the player by one accepted input transfer
        function void take_item(logic kind, logic [7:0] b);
            bit [23:0] a;
            bit        lit;
            if (kind == cpbl_pkg::KIND_BUTTON) begin
                // Drop presses during playback
                if (playing) return;
                a       = clip_address(clip_no);
                left    = clip_length(clip_no);
                level   = '0;
                falling = 1'b0;
                playing = 1'b1;
                starts++;
                add_out(cpbl_pkg::READ_CMD, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
                add_out(a[23:16], 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
                add_out(a[15:8], 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
                add_out(a[7:0], 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1);
                return;
            end
            // Drop ticks while idle
            if (!playing) return;
            duty = b;
            // Step the breathing level on every LED_STEP_SAMPLES boundary
            if (left % LED_STEP_SAMPLES == 0) begin
                if (!falling) begin
                    level = level + 1'b1;
                    if (level == LED_LEVELS) falling = 1'b1;
                end else begin
                    level = level - 1'b1;
                    if (level == 0) falling = 1'b0;
                end
            end
            lit = (left % LED_LEVELS) < level;
            if (left <= 1) begin
                left    = '0;
                playing = 1'b0;
                clip_no = (clip_no + 1 >= NUM_CLIPS) ? 3'd0 : clip_no + 3'd1;
                clips_ended++;
                add_out(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
            end else begin
                left = left - 1'b1;
                add_out(8'h00, 1'b0, 1'b1, 1'b1, lit, 1'b0, 1'b1);
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTS) $display("MISMATCH: %s", msg);
        endtask

        task cmp_field(string name, logic [7:0] g, logic [7:0] w);
            if (g !== w)
                report($sformatf("result %0d: %s is %0h, expected %0h", checked, name, g, w));
        endtask

        // Compare one result transfer with the oldest prediction
        task check_out(t_player_out got);
            t_player_out want;
            checked++;
            if (pending.size() == 0) begin
                report($sformatf("result %0d arrived with nothing expected", checked));
                return;
            end
            want = pending.pop_front();
            cmp_field("mem_byte", got.mem_byte, want.mem_byte);
            cmp_field("mem_byte_valid", got.mem_byte_valid, want.mem_byte_valid);
            cmp_field("select_active", got.select_active, want.select_active);
            cmp_field("pwm_duty", got.pwm_duty, want.pwm_duty);
            cmp_field("pwm_on", got.pwm_on, want.pwm_on);
            cmp_field("led_on", got.led_on, want.led_on);
            cmp_field("clip_done", got.clip_done, want.clip_done);
            cmp_field("last_of_run", got.last_of_run, want.last_of_run);
        endtask
    endclass

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_valid       = 1'b0;
    logic       i_kind        = 1'b0;
    logic [7:0] i_sample_byte = 8'h00;
    logic       i_stall       = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_mem_byte;
    logic       o_mem_byte_valid;
    logic       o_select_active;
    logic [7:0] o_pwm_duty;
    logic       o_pwm_on;
    logic       o_led_on;
    logic       o_clip_done;
    logic       o_last_of_run;

    player_scoreboard sb;
    int unsigned      cycles     = 0;
    int unsigned      items_sent = 0;
    int unsigned      burst_left = 0;
    int unsigned      burst_max  = 4;
    int unsigned      gap_max    = 3;
    logic             hold_token = 1'b0;
    logic             hold_seen  = 1'b0;
    int unsigned      hold_left  = 0;
    int unsigned      rx_mode    = 0;
    int unsigned      rx_left    = 0;

    clip_player_breathing_led_top #(
        .NUM_CLIPS       (NUM_CLIPS),
        .LED_LEVELS      (LED_LEVELS),
        .LED_STEP_SAMPLES(LED_STEP_SAMPLES),
        .ADDR_BITS       (ADDR_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_kind          (i_kind),
        .i_sample_byte   (i_sample_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_mem_byte      (o_mem_byte),
        .o_mem_byte_valid(o_mem_byte_valid),
        .o_select_active (o_select_active),
        .o_pwm_duty      (o_pwm_duty),
        .o_pwm_on        (o_pwm_on),
        .o_led_on        (o_led_on),
        .o_clip_done     (o_clip_done),
        .o_last_of_run   (o_last_of_run)
    );

    always #5 i_clk = ~i_clk;

    // Count cycles and stop a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycles, sb.pending.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Check result transfers and drive the receiver stall pattern
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_out({o_mem_byte, o_mem_byte_valid, o_select_active, o_pwm_duty,
                          o_pwm_on, o_led_on, o_clip_done, o_last_of_run});
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(16, 200);
        end else begin
            rx_left--;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            case (rx_mode)
                0:       i_stall <= 1'b0;
                1:       i_stall <= ($urandom_range(0, 7) == 0);
                2:       i_stall <= $urandom_range(0, 1);
                default: i_stall <= (rx_left % 5) < 2;
            endcase
        end
    end

    // Offer one input transfer and hold it until taken
    task automatic send_item(input logic kind, input logic [7:0] b);
        i_valid       <= 1'b1;
        i_kind        <= kind;
        i_sample_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.take_item(kind, b);
        items_sent++;
    endtask

    // Drop valid and put junk on the payload while pausing the input
    task automatic pause_input(input int unsigned n);
        if (n == 0) return;
        i_valid       <= 1'b0;
        i_kind        <= 1'($urandom);
        i_sample_byte <= 8'($urandom);
        repeat (n) @(posedge i_clk);
    endtask

    // Send in bursts of random length with random gaps between them
    task automatic offer(input logic kind, input logic [7:0] b);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) pause_input($urandom_range(1, gap_max + 1));
            burst_left = $urandom_range(1, burst_max);
        end
        burst_left--;
        send_item(kind, b);
    endtask

    // Hold the sender until every predicted result has arrived
    task automatic wait_drained();
        i_valid    <= 1'b0;
        burst_left  = 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [7:0]  corner_bytes [8];
        logic        kind;
        corner_bytes = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA};
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: ticks while idle, start, press during playback, byte extremes
        send_item(cpbl_pkg::KIND_TICK, 8'hFF);
        send_item(cpbl_pkg::KIND_TICK, 8'h00);
        send_item(cpbl_pkg::KIND_BUTTON, 8'hFF);
        send_item(cpbl_pkg::KIND_BUTTON, 8'h00);
        foreach (corner_bytes[j]) send_item(cpbl_pkg::KIND_TICK, corner_bytes[j]);
        pause_input(3);
        send_item(cpbl_pkg::KIND_BUTTON, 8'h5A);
        send_item(cpbl_pkg::KIND_TICK, 8'hC3);

        // Long receiver hold while the sender keeps offering, then a full drain
        hold_token <= ~hold_token;
        repeat (24) send_item(cpbl_pkg::KIND_TICK, 8'($urandom));
        wait_drained();

        // Random mix of ticks and ignored presses
        repeat (120) begin
            kind = ($urandom_range(0, 7) == 0) ? cpbl_pkg::KIND_BUTTON : cpbl_pkg::KIND_TICK;
            if ($urandom_range(0, 49) == 0) begin
                burst_max = $urandom_range(1, 12);
                gap_max   = $urandom_range(0, 6);
            end
            offer(kind, 8'($urandom));
        end
        repeat (20) offer(cpbl_pkg::KIND_TICK, 8'($urandom));

        wait_drained();
        $display("Run covered %0d input transfers and %0d results over %0d cycles.",
                 items_sent, sb.checked, cycles);
        $display("Clip starts: %0d, clips played to the end: %0d, mismatches: %0d.",
                 sb.starts, sb.clips_ended, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
src/cpbl_pkg.sv
src/cpbl_fifo.sv
src/cpbl_front.sv
src/cpbl_back.sv
src/clip_player_breathing_led_top.sv
test/clip_player_breathing_led_top_tb.sv
